// ===== hdl/rsqh_pkg.sv =====
`default_nettype none
package rsqh_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int ORG_W  = 32;
  localparam int DIR_W  = 18;
  localparam int UV_W   = 17;
  localparam int DIST_W = 31;

  // quotient bits produced by each divider, one per stage
  localparam int QUO_W = 31;

  localparam logic [UV_W-1:0]   UV_MAX   = '1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

endpackage
`default_nettype wire

// ===== hdl/rsqh_div.sv =====
`default_nettype none
module rsqh_div import rsqh_pkg::*; #(
  parameter int NW = FRAC_BITS_DEF + 35,
  parameter int DW = 19,
  parameter int QW = QUO_W
) (
  input  wire logic          clk,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quo
);

  // restoring division, one quotient bit per stage, msb first;
  // caller keeps num below den << QW
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [CW-1:0] sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign sh = CW'(den_in) << (QW - 1 - k);
    assign ge = CW'(rem_in) >= sh;

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? NW'(CW'(rem_in) - sh) : rem_in;
      den_r[k] <= den_in;
      quo_r[k] <= ge ? (quo_in | (QW'(1) << (QW - 1 - k))) : quo_in;
    end
  end

  assign quo = quo_r[QW-1];

endmodule
`default_nettype wire

// ===== hdl/ray_screen_quad_hit.sv =====
`default_nettype none
// An accepted ray passes the four arithmetic stages, the divider stages and the output register.
// Throughput: one ray per cycle; busy is never raised, as nothing stalls.
// Depth is set by the three restoring dividers (one quotient bit per stage,
// QUO_W stages) behind four arithmetic stages.
// Reset (rst_n low, synchronous) clears the valid bits, so results in flight are dropped.
// The receiver cannot stall: out_valid marks each result word for one cycle.
module ray_screen_quad_hit import rsqh_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [ORG_W-1:0] in_origin_x,
  input  wire logic signed [ORG_W-1:0] in_origin_y,
  input  wire logic signed [ORG_W-1:0] in_origin_z,
  input  wire logic signed [DIR_W-1:0] in_dir_x,
  input  wire logic signed [DIR_W-1:0] in_dir_y,
  input  wire logic signed [DIR_W-1:0] in_dir_z,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic                         out_which_triangle,
  output logic             [UV_W-1:0]  out_screen_u,
  output logic             [UV_W-1:0]  out_screen_v,
  output logic             [DIST_W-1:0] out_distance
);

  localparam longint SZ_L = ((64'sd219 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
  localparam logic signed [32:0] VX_S = 33'(64'sd3 <<< FRAC_BITS);
  localparam logic signed [32:0] VY_S = 33'(64'sd8 <<< FRAC_BITS);
  localparam logic signed [32:0] SZ_S = 33'(SZ_L);
  localparam int UNW = FRAC_BITS + 22;
  localparam int DNW = FRAC_BITS + 35;
  localparam int UDW = 22;
  localparam int DDW = 19;
  localparam logic [UV_W-1:0] UV_LIM =
    (FRAC_BITS > 16) ? UV_MAX : UV_W'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic vld;
    logic hit;
    logic tri_sel;
    logic dsat;
  } sb_t;

  assign busy = 1'b0;

  // stage 1: offsets from the corner and the plane
  logic signed [32:0] s1_ax_r, s1_ay_r, s1_gap_r;
  logic signed [DIR_W-1:0] s1_dx_r, s1_dy_r, s1_dz_r;
  logic s1_v_r;
  logic signed [32:0] s1_ax_nxt, s1_ay_nxt, s1_gap_nxt;

  always_comb begin
    s1_ax_nxt  = {in_origin_x[ORG_W-1], in_origin_x} - VX_S;
    s1_ay_nxt  = {in_origin_y[ORG_W-1], in_origin_y} - VY_S;
    s1_gap_nxt = SZ_S - {in_origin_z[ORG_W-1], in_origin_z};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= start && !busy;
    end
    s1_ax_r  <= s1_ax_nxt;
    s1_ay_r  <= s1_ay_nxt;
    s1_gap_r <= s1_gap_nxt;
    s1_dx_r  <= in_dir_x;
    s1_dy_r  <= in_dir_y;
    s1_dz_r  <= in_dir_z;
  end

  // stage 2: the four products
  logic signed [50:0] s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r;
  logic signed [32:0] s2_gap_r;
  logic signed [DIR_W-1:0] s2_dz_r;
  logic s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_p1_r  <= s1_ax_r * s1_dz_r;
    s2_p2_r  <= s1_gap_r * s1_dx_r;
    s2_p3_r  <= s1_ay_r * s1_dz_r;
    s2_p4_r  <= s1_gap_r * s1_dy_r;
    s2_gap_r <= s1_gap_r;
    s2_dz_r  <= s1_dz_r;
  end

  // stage 3: sums, folded so that the denominator is positive
  logic signed [52:0] s3_a_r, s3_b_r;
  logic signed [33:0] s3_tn_r;
  logic [DIR_W-1:0] s3_dzp_r;
  logic s3_z_r, s3_v_r;
  logic signed [51:0] a_sum, b_sum;
  logic signed [52:0] s3_a_nxt, s3_b_nxt;
  logic signed [33:0] s3_tn_nxt;
  logic [DIR_W-1:0] s3_dzp_nxt;
  logic neg;

  always_comb begin
    neg        = s2_dz_r[DIR_W-1];
    a_sum      = 52'(s2_p1_r) + 52'(s2_p2_r);
    b_sum      = 52'(s2_p3_r) + 52'(s2_p4_r);
    s3_a_nxt   = neg ? -53'(a_sum) : 53'(a_sum);
    s3_b_nxt   = neg ? -53'(b_sum) : 53'(b_sum);
    s3_tn_nxt  = neg ? -34'(s2_gap_r) : 34'(s2_gap_r);
    s3_dzp_nxt = neg ? DIR_W'(-s2_dz_r) : DIR_W'(s2_dz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_a_r   <= s3_a_nxt;
    s3_b_r   <= s3_b_nxt;
    s3_tn_r  <= s3_tn_nxt;
    s3_dzp_r <= s3_dzp_nxt;
    s3_z_r   <= (s2_dz_r == '0);
  end

  // stage 4: barycentric bounds, triangle choice, divider operands
  logic signed [55:0] ea, eb2, lim;
  logic signed [55:0] nu0, nv0, sm0, nu1, nv1, sm1;
  logic [63:0] nd_w;
  logic ok0, ok1, tpos;
  logic s4_hit_nxt, s4_tri_nxt;
  logic [UNW-1:0] s4_nu_nxt, s4_nv_nxt;

  logic s4_v_r, s4_hit_r, s4_tri_r;
  logic [UNW-1:0] s4_nu_r, s4_nv_r;
  logic [DNW-1:0] s4_nd_r;
  logic [UDW-1:0] s4_du_r;
  logic [DDW-1:0] s4_dd_r;

  always_comb begin
    ea   = 56'(s3_a_r);
    eb2  = 56'(s3_b_r) <<< 1;
    lim  = 56'(s3_dzp_r) << (FRAC_BITS + 3);
    nu0  = eb2 - ea;
    nv0  = -eb2;
    sm0  = -ea;
    nu1  = -ea;
    nv1  = ea - eb2;
    sm1  = -eb2;
    tpos = !s3_tn_r[33] && (s3_tn_r != '0);
    ok0  = !nu0[55] && (nu0 <= lim) && !nv0[55] && (sm0 <= lim);
    ok1  = !nu1[55] && (nu1 <= lim) && !nv1[55] && (sm1 <= lim);
    s4_hit_nxt = !s3_z_r && tpos && (ok0 || ok1);
    s4_tri_nxt = !ok0;
    s4_nu_nxt  = UNW'((sm0 <<< 1) + (lim >>> FRAC_BITS));
    s4_nv_nxt  = UNW'((sm1 <<< 1) + (lim >>> FRAC_BITS));
    nd_w = (64'(s3_tn_r) << (FRAC_BITS + 1)) + 64'(s3_dzp_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
    s4_hit_r <= s4_hit_nxt;
    s4_tri_r <= s4_tri_nxt;
    s4_nu_r  <= s4_nu_nxt;
    s4_nv_r  <= s4_nv_nxt;
    s4_nd_r  <= DNW'(nd_w);
    s4_du_r  <= {s3_dzp_r, 4'b0000};
    s4_dd_r  <= {s3_dzp_r, 1'b0};
  end

  // dividers: rounded quotients (2n + d) / (2d)
  logic [QUO_W-1:0] qu, qv, qd;

  rsqh_div #(.NW(UNW), .DW(UDW), .QW(QUO_W)) u_div_u (
    .clk(clk), .num(s4_nu_r), .den(s4_du_r), .quo(qu)
  );

  rsqh_div #(.NW(UNW), .DW(UDW), .QW(QUO_W)) u_div_v (
    .clk(clk), .num(s4_nv_r), .den(s4_du_r), .quo(qv)
  );

  rsqh_div #(.NW(DNW), .DW(DDW), .QW(QUO_W)) u_div_d (
    .clk(clk), .num(s4_nd_r), .den(s4_dd_r), .quo(qd)
  );

  // side band runs alongside the divider stages
  sb_t sb_r [QUO_W];
  sb_t sb_nxt;

  always_comb begin
    sb_nxt.vld     = s4_v_r;
    sb_nxt.hit     = s4_hit_r;
    sb_nxt.tri_sel = s4_tri_r;
    sb_nxt.dsat    = 64'(s4_nd_r) >= (64'(s4_dd_r) << QUO_W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUO_W; k++) begin
        sb_r[k].vld <= 1'b0;
      end
    end else begin
      sb_r[0].vld <= sb_nxt.vld;
      for (int k = 1; k < QUO_W; k++) begin
        sb_r[k].vld <= sb_r[k-1].vld;
      end
    end
    sb_r[0].hit     <= sb_nxt.hit;
    sb_r[0].tri_sel <= sb_nxt.tri_sel;
    sb_r[0].dsat    <= sb_nxt.dsat;
    for (int k = 1; k < QUO_W; k++) begin
      sb_r[k].hit     <= sb_r[k-1].hit;
      sb_r[k].tri_sel <= sb_r[k-1].tri_sel;
      sb_r[k].dsat    <= sb_r[k-1].dsat;
    end
  end

  // output word, saturated; a miss gives all zeros
  sb_t sb_end;
  logic out_valid_r, out_hit_r, out_tri_r;
  logic [UV_W-1:0] out_u_r, out_v_r, out_u_nxt, out_v_nxt;
  logic [DIST_W-1:0] out_d_r, out_d_nxt;

  always_comb begin
    sb_end    = sb_r[QUO_W-1];
    out_u_nxt = (qu > QUO_W'(UV_MAX)) ? UV_MAX : qu[UV_W-1:0];
    out_v_nxt = (qv > QUO_W'(UV_MAX)) ? UV_MAX : qv[UV_W-1:0];
    out_d_nxt = sb_end.dsat ? DIST_MAX : qd[DIST_W-1:0];
    if (!sb_end.hit) begin
      out_u_nxt = '0;
      out_v_nxt = '0;
      out_d_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sb_end.vld;
    end
    out_hit_r <= sb_end.hit;
    out_tri_r <= sb_end.hit && sb_end.tri_sel;
    out_u_r   <= out_u_nxt;
    out_v_r   <= out_v_nxt;
    out_d_r   <= out_d_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_which_triangle = out_tri_r;
  assign out_screen_u       = out_u_r;
  assign out_screen_v       = out_v_r;
  assign out_distance       = out_d_r;

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (!out_which_triangle && out_screen_u == '0 &&
                                 out_screen_v == '0 && out_distance == '0))
    else $error("miss word carries payload");

  a_uv_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_screen_u <= UV_LIM && out_screen_v <= UV_LIM))
    else $error("screen coordinate beyond one");

  a_div_range : assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && s4_hit_r) |->
      (64'(s4_nu_r) < (64'(s4_du_r) << QUO_W) && 64'(s4_nv_r) < (64'(s4_du_r) << QUO_W)))
    else $error("divider operand out of range");

  a_hit_dist : assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && s4_hit_r) |-> (s4_dd_r != '0))
    else $error("hit with zero determinant");

endmodule
`default_nettype wire
